// File: rtl/fpss_pkg.sv
package fpss_pkg;

   // fixed field widths
   localparam int DATA_W      = 32;
   localparam int SLOT_WORDS  = 8;
   localparam int WORD_IDX_W  = 3;
   localparam int WCNT_W      = WORD_IDX_W + 1;
   localparam int OFF_W       = 7;
   localparam int LIMIT_W     = 16;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   // default page geometry
   localparam int PAGE_WORDS_DEF  = 512;
   localparam int INDEX_WORDS_DEF = 64;

   // config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_LIMIT = CSR_IDX_W'(0);
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(32);

   // stream payload widths
   localparam int REQ_DATA_W = SLOT_WORDS * DATA_W;
   localparam int RSP_BITS   = OFF_W + SLOT_WORDS * DATA_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   // commands
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_DATA = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_LIMIT   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_ERASED  = 2'd3;

   typedef logic [SLOT_WORDS-1:0][DATA_W-1:0] word_array_type;

endpackage

// File: rtl/fpss_slot_ram.sv
module fpss_slot_ram #(
   parameter int SLOT_COUNT = 56
) (
   input  logic clock,
   input  logic we,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1) + fpss_pkg::WORD_IDX_W - 1:0] addr,
   input  logic [fpss_pkg::DATA_W-1:0] wdata,
   output logic [fpss_pkg::DATA_W-1:0] rdata
);
   import fpss_pkg::*;

   localparam int DEPTH = SLOT_COUNT * SLOT_WORDS;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/fpss_ctrl.sv
module fpss_ctrl #(
   parameter int SLOT_COUNT = 56
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [fpss_pkg::CMD_W-1:0] req_cmd,
   input  fpss_pkg::word_array_type req_words,
   input  logic [fpss_pkg::LIMIT_W-1:0] write_limit,
   output logic mem_we,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1) + fpss_pkg::WORD_IDX_W - 1:0] mem_addr,
   output logic [fpss_pkg::DATA_W-1:0] mem_wdata,
   input  logic [fpss_pkg::DATA_W-1:0] mem_rdata,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [fpss_pkg::STATUS_W-1:0] rsp_status,
   output logic [fpss_pkg::OFF_W-1:0] rsp_offset,
   output fpss_pkg::word_array_type rsp_words
);
   import fpss_pkg::*;

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WR   = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [1:0] WSEL_ZERO = 2'd0;
   localparam logic [1:0] WSEL_ONES = 2'd1;
   localparam logic [1:0] WSEL_DATA = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [WCNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LIMIT_W-1:0]    writes_done_ff, writes_done_in;
   logic                  erase_used_ff, erase_used_in;
   logic [SLOT_IDX_W-1:0] slot_ff, slot_in;
   word_array_type        data_ff, data_in;
   logic [STATUS_W-1:0]   stat_ff, stat_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [1:0]            wsel_ff, wsel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [OFF_W-1:0]      rsp_off_ff, rsp_off_in;
   word_array_type        rsp_words_ff, rsp_words_in;

   logic [SLOT_IDX_W-1:0] cur_slot;
   logic [SLOT_IDX_W-1:0] nxt_slot;
   logic [OFF_W-1:0]      cur_off;
   logic [WCNT_W-1:0]     cnt_dec;
   logic [WORD_IDX_W-1:0] rd_idx;

   // mark prefix length is the fill count, current slot is one below it
   assign cur_slot = SLOT_IDX_W'(count_ff - CNT_W'(1));
   assign cur_off  = OFF_W'(count_ff) - OFF_W'(1);
   assign nxt_slot = (count_ff >= CNT_W'(SLOT_COUNT)) ? '0 : SLOT_IDX_W'(count_ff);
   assign cnt_dec  = cnt_ff - WCNT_W'(1);
   assign rd_idx   = cnt_dec[WORD_IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      count_in       = count_ff;
      writes_done_in = writes_done_ff;
      erase_used_in  = erase_used_ff;
      slot_in        = slot_ff;
      data_in        = data_ff;
      stat_in        = stat_ff;
      off_in         = off_ff;
      wsel_in        = wsel_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_stat_in    = rsp_stat_ff;
      rsp_off_in     = rsp_off_ff;
      rsp_words_in   = rsp_words_ff;
      req_ready      = (state_ff == S_IDLE);
      mem_we         = 1'b0;
      mem_addr       = {slot_ff, cnt_ff[WORD_IDX_W-1:0]};
      mem_wdata      = data_ff[cnt_ff[WORD_IDX_W-1:0]];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               data_in  = req_words;
               cnt_in   = '0;
               wsel_in  = WSEL_ZERO;
               stat_in  = STAT_OK;
               off_in   = cur_off;
               state_in = S_DONE;
               case (req_cmd)
                  CMD_READ: begin
                     if (count_ff == '0) begin
                        stat_in = STAT_NO_DATA;
                        off_in  = '1;
                        wsel_in = WSEL_ONES;
                     end else begin
                        wsel_in  = WSEL_DATA;
                        slot_in  = cur_slot;
                        state_in = S_RD;
                     end
                  end
                  CMD_WRITE: begin
                     if (writes_done_ff >= write_limit) begin
                        stat_in = STAT_LIMIT;
                     end else begin
                        // a full page wraps to slot 0, which drops every mark
                        writes_done_in = writes_done_ff + LIMIT_W'(1);
                        slot_in        = nxt_slot;
                        count_in       = CNT_W'(nxt_slot) + CNT_W'(1);
                        off_in         = OFF_W'(nxt_slot);
                        state_in       = S_WR;
                     end
                  end
                  CMD_ERASE: begin
                     if (erase_used_ff) begin
                        stat_in = STAT_ERASED;
                     end else begin
                        erase_used_in = 1'b1;
                        count_in      = '0;
                        off_in        = '1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + WCNT_W'(1);
            if (cnt_ff == WCNT_W'(SLOT_WORDS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            // read data arrives in the cycle after its address
            if (cnt_ff != '0) begin
               data_in[rd_idx] = mem_rdata;
            end
            cnt_in = cnt_ff + WCNT_W'(1);
            if (cnt_ff == WCNT_W'(SLOT_WORDS)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_off_in   = off_ff;
               case (wsel_ff)
                  WSEL_DATA: rsp_words_in = data_ff;
                  WSEL_ONES: rsp_words_in = '1;
                  default:   rsp_words_in = '0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         writes_done_ff <= '0;
         erase_used_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         writes_done_ff <= writes_done_in;
         erase_used_ff  <= erase_used_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      slot_ff      <= slot_in;
      data_ff      <= data_in;
      stat_ff      <= stat_in;
      off_ff       <= off_in;
      wsel_ff      <= wsel_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_words_ff <= rsp_words_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_offset = rsp_off_ff;
   assign rsp_words  = rsp_words_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOT_COUNT))
      else $error("fill count beyond slot count");

   a_write_top_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(slot_ff) + CNT_W'(1) == count_ff))
      else $error("program outside the newest slot");

   a_erase_sticky: assert property (@(posedge clock) disable iff (reset)
      erase_used_ff |=> erase_used_ff)
      else $error("one-time erase flag dropped");

endmodule

// File: rtl/flash_param_slot_store_top.sv
// channel | dir | tdata (low bit up)                  | tuser
// req     | in  | word0..word7                        | cmd
// rsp     | out | slot_offset, out_word0..7, pad bit  | status
// csr     | in  | apb, write_limit at byte address 0  | -
//
// read: accept, read the slot words through the single slot ram port, then load the result
// write: accept, program the slot words one by one on the ram port, then load the result
// erase, nop and refused commands: accept, then go straight to loading the result
// reset: synchronous; clears the mark count, write count and one-time erase flag
// rsp stall: a finished item waits in the done state, the next one is taken after it moves on
module flash_param_slot_store_top #(
   parameter int PAGE_WORDS  = fpss_pkg::PAGE_WORDS_DEF,
   parameter int INDEX_WORDS = fpss_pkg::INDEX_WORDS_DEF
) (
   input  logic clock,
   input  logic reset,
   // word0 [31:0] .. word7 [255:224]
   input  logic [fpss_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [fpss_pkg::CMD_W-1:0] req_tuser,
   input  logic req_tvalid,
   output logic req_tready,
   // slot_offset [6:0], out_word0 [38:7] .. out_word7 [262:231], zero [263]
   output logic [fpss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [fpss_pkg::STATUS_W-1:0] rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [fpss_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fpss_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fpss_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import fpss_pkg::*;

   // slots that fit behind the mark area, capped by the mark count
   localparam int RAW_SLOTS  = (PAGE_WORDS > INDEX_WORDS) ?
                               ((PAGE_WORDS - INDEX_WORDS) / SLOT_WORDS) : 0;
   localparam int CAP_SLOTS  = (RAW_SLOTS > INDEX_WORDS) ? INDEX_WORDS : RAW_SLOTS;
   localparam int SLOT_COUNT = (CAP_SLOTS < 1) ? 1 : CAP_SLOTS;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ADDR_W     = SLOT_IDX_W + WORD_IDX_W;

   logic [LIMIT_W-1:0]   write_limit_ff, write_limit_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_addr;
   logic [DATA_W-1:0]    mem_wdata;
   logic [DATA_W-1:0]    mem_rdata;
   logic [OFF_W-1:0]     rsp_offset;
   word_array_type       rsp_words;
   word_array_type       req_words;

   // register file: one limit register, written on the access phase
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      write_limit_in = write_limit_ff;
      if (csr_wr && (csr_idx == REG_WRITE_LIMIT)) begin
         write_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WRITE_LIMIT: csr_prdata = CSR_DATA_W'(write_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_limit_ff <= LIMIT_RESET;
      end else begin
         write_limit_ff <= write_limit_in;
      end
   end

   // word0 sits in the low bits of the request transfer
   assign req_words = word_array_type'(req_tdata);

   fpss_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_words   (req_words),
      .write_limit (write_limit_ff),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_offset  (rsp_offset),
      .rsp_words   (rsp_words)
   );

   // slot words, one port shared by programs and reads
   fpss_slot_ram #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_words, rsp_offset};

endmodule

// File: verif/flash_param_slot_store_top_test.sv
module flash_param_slot_store_top_test;
   import fpss_pkg::*;

   // page geometry as instantiated with the default parameters
   localparam int RAW_SLOTS = (PAGE_WORDS_DEF > INDEX_WORDS_DEF) ?
                              (PAGE_WORDS_DEF - INDEX_WORDS_DEF) / SLOT_WORDS : 0;
   localparam int CAP_SLOTS = (RAW_SLOTS > INDEX_WORDS_DEF) ? INDEX_WORDS_DEF : RAW_SLOTS;
   localparam int SLOT_CNT  = (CAP_SLOTS < 1) ? 1 : CAP_SLOTS;

   // cycles with no transfer before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // cycles to wait after the last result, longer than any item's latency
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    offset;
      word_array_type      words;
   } slot_result_type;

   logic clock;
   logic reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic req_tvalid;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // shadow copy of the page, counters and register
   logic [INDEX_WORDS_DEF-1:0] shadow_marks;   // bit set: mark programmed
   word_array_type             shadow_slots [SLOT_CNT];
   logic [LIMIT_W-1:0]         shadow_writes_done;
   logic [LIMIT_W-1:0]         shadow_write_limit;
   bit                         shadow_erase_used;

   slot_result_type pending_responses [$];
   int  err_count;
   int  idle_cycles;
   bit  req_gaps_on;
   bit  rsp_stalls_on;

   flash_param_slot_store_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // erased flash reads as ones, and every mark goes back to unprogrammed
   function automatic void erase_shadow_page();
      shadow_marks = '0;
      foreach (shadow_slots[i]) shadow_slots[i] = '1;
   endfunction

   function automatic slot_result_type predict_store_response(logic [CMD_W-1:0] cmd,
                                                              word_array_type words);
      slot_result_type res;
      int cur;
      int nxt;
      // current slot: leading programmed marks, minus one
      cur = 0;
      while (cur < INDEX_WORDS_DEF && shadow_marks[cur]) cur++;
      cur = cur - 1;
      res.status = STAT_OK;
      res.offset = OFF_W'(cur);
      res.words  = '0;
      case (cmd)
         CMD_READ: begin
            if (cur < 0) begin
               res.status = STAT_NO_DATA;
               res.words  = '1;
            end else begin
               res.words = shadow_slots[(cur < SLOT_CNT) ? cur : SLOT_CNT - 1];
            end
         end
         CMD_WRITE: begin
            if (shadow_writes_done >= shadow_write_limit) begin
               res.status = STAT_LIMIT;
            end else begin
               shadow_writes_done = shadow_writes_done + 1'b1;
               nxt = cur + 1;
               // page full: wipe everything and restart at slot 0
               if (nxt >= SLOT_CNT) begin
                  erase_shadow_page();
                  nxt = 0;
               end
               shadow_slots[nxt] = words;
               shadow_marks[nxt] = 1'b1;
               res.offset = OFF_W'(nxt);
            end
         end
         CMD_ERASE: begin
            if (shadow_erase_used) begin
               res.status = STAT_ERASED;
            end else begin
               shadow_erase_used = 1'b1;
               erase_shadow_page();
               res.offset = OFF_W'(-1);
            end
         end
         default: ;   // no operation, just reports the current slot
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // one request transfer; valid stays high afterwards so back-to-back items
   // never drop and raise it within the same step
   task automatic send_command(input logic [CMD_W-1:0] cmd, input word_array_type words);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= words;
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(predict_store_response(cmd, words));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   function automatic word_array_type random_words();
      word_array_type w;
      case ($urandom_range(0, 15))
         0:       w = '0;
         1:       w = '1;
         default: foreach (w[i]) w[i] = $urandom();
      endcase
      return w;
   endfunction

   // apb: read back the current value, write the new one, read it back again;
   // psel stays high across the three transfers
   task automatic set_write_limit(input logic [LIMIT_W-1:0] value);
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(shadow_write_limit);
      for (int phase = 0; phase < 3; phase++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= (phase == 1);
         csr_paddr   <= {REG_WRITE_LIMIT, 2'b00};
         csr_pwdata  <= CSR_DATA_W'(value);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (phase == 1) begin
            shadow_write_limit = value;
            want = CSR_DATA_W'(value);
         end else if (csr_prdata !== want) begin
            $error("write_limit readback: expected %h, got %h", want, csr_prdata);
            err_count++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------

   // ready drops for a random number of cycles before each result when enabled
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      slot_result_type exp_res;
      word_array_type got_words;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            $error("result transfer with no prediction waiting");
            err_count++;
         end else begin
            exp_res   = pending_responses.pop_front();
            got_words = rsp_tdata[OFF_W +: SLOT_WORDS * DATA_W];
            if (rsp_tuser !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata[OFF_W-1:0] !== exp_res.offset) begin
               $error("slot_offset: expected %h, got %h", exp_res.offset,
                      rsp_tdata[OFF_W-1:0]);
               err_count++;
            end
            for (int i = 0; i < SLOT_WORDS; i++) begin
               if (got_words[i] !== exp_res.words[i]) begin
                  $error("out_word%0d: expected %h, got %h", i, exp_res.words[i],
                         got_words[i]);
                  err_count++;
               end
            end
         end
      end
   end

   // hang detection: any transfer on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // empty page: no data on read, a zero limit refuses the first write
   task automatic test_empty_page();
      set_write_limit(16'd0);
      send_command(CMD_READ, random_words());
      send_command(CMD_NOP, random_words());
      send_command(CMD_WRITE, '1);
      send_command(CMD_READ, '0);
      drain_responses();
   endtask

   // every command, data extremes, the write limit boundary and the one-time erase
   task automatic test_directed_ops();
      word_array_type alt;
      foreach (alt[i]) alt[i] = (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA;
      set_write_limit(16'd3);
      send_command(CMD_WRITE, '0);
      send_command(CMD_READ, '0);
      send_command(CMD_WRITE, '1);
      send_command(CMD_READ, '0);
      send_command(CMD_WRITE, alt);
      send_command(CMD_WRITE, random_words());   // limit reached
      send_command(CMD_READ, '1);
      send_command(CMD_NOP, '1);
      send_command(CMD_ERASE, '0);               // the one allowed erase
      send_command(CMD_READ, '0);
      send_command(CMD_ERASE, random_words());   // already used
      drain_responses();
      set_write_limit(16'hFFFF);
      send_command(CMD_WRITE, ~alt);
      send_command(CMD_READ, '0);
      send_command(CMD_ERASE, '1);
      send_command(CMD_NOP, '0);
      drain_responses();
   endtask

   // fill the page past its last slot so it wraps to slot 0
   task automatic test_page_wrap();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int n = 0; n < SLOT_CNT + 4; n++) begin
         send_command(CMD_WRITE, random_words());
         if (n % 5 == 0 || n >= SLOT_CNT - 2) send_command(CMD_READ, random_words());
      end
      drain_responses();
   endtask

   // mixed traffic in phases with different limits and idling patterns
   task automatic test_random_traffic();
      int pick;
      logic [CMD_W-1:0] cmd;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_write_limit(16'hFFFF);
            1: set_write_limit(shadow_writes_done + LIMIT_W'($urandom_range(0, 40)));
            2: set_write_limit(LIMIT_W'($urandom_range(0, 65535)));
            default: set_write_limit(16'hFFFF);
         endcase
         req_gaps_on   = (phase == 0 || phase == 3);
         rsp_stalls_on = (phase == 0 || phase == 2);
         for (int n = 0; n < 80; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      cmd = CMD_WRITE;
            else if (pick < 85) cmd = CMD_READ;
            else if (pick < 93) cmd = CMD_NOP;
            else                cmd = CMD_ERASE;
            // now and then let everything in flight come back first
            if ($urandom_range(0, 39) == 0) drain_responses();
            send_command(cmd, random_words());
         end
         drain_responses();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_READ;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      err_count   = 0;
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      // shadow state after reset
      erase_shadow_page();
      shadow_writes_done = '0;
      shadow_write_limit = LIMIT_RESET;
      shadow_erase_used  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_page();
      test_directed_ops();
      test_page_wrap();
      test_random_traffic();

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
